### design/icr_pkg.sv
// Package for the impulse collision response block.
// Beat structs, datapath widths, pipeline latency and outcome codes; no dependencies.
package icr_pkg;

  localparam int COORD_W = 24;
  localparam int MASS_W  = 16;
  localparam int REST_W  = 9;

  localparam int DIFF_W  = COORD_W + 1;
  localparam int MAG_W   = COORD_W + 1;
  localparam int K_W     = $clog2(MAG_W);
  localparam int RM_W    = 14;
  localparam int RED_W   = RM_W + 1;
  localparam int SQ_W    = 2 * RM_W;
  localparam int DEN_W   = SQ_W + 1;
  localparam int S_W     = COORD_W + 16;
  localparam int SMAG_W  = S_W - 1;
  localparam int NUM_W   = SMAG_W + RM_W;
  localparam int QUO_W   = COORD_W + 2;
  localparam int HI_W    = NUM_W - QUO_W;
  localparam int MSUM_W  = MASS_W + 1;
  localparam int GNUM_W  = MASS_W + 10;
  localparam int GAIN_W  = 18;
  localparam int PROD_W  = QUO_W + GAIN_W;
  localparam int TERM_W  = PROD_W - 16;
  localparam int SUM_W   = TERM_W + 1;

  localparam int GEOM_STAGES  = 6;
  localparam int APPLY_STAGES = 2;
  localparam int LATENCY      = GEOM_STAGES + QUO_W + APPLY_STAGES;

  localparam logic [REST_W-1:0] REST_ONE = REST_W'(256);

  localparam logic signed [SUM_W-1:0] SAT_HI =
    SUM_W'((64'sd1 <<< (COORD_W - 1)) - 64'sd1);
  localparam logic signed [SUM_W-1:0] SAT_LO = -SAT_HI - SUM_W'(1);

  localparam logic [1:0] OUT_IMPULSE  = 2'd0;
  localparam logic [1:0] OUT_SEPARATE = 2'd1;
  localparam logic [1:0] OUT_COINCIDE = 2'd2;

  typedef struct packed {
    logic signed [COORD_W-1:0] pos_a_x;
    logic signed [COORD_W-1:0] pos_a_y;
    logic signed [COORD_W-1:0] pos_b_x;
    logic signed [COORD_W-1:0] pos_b_y;
    logic signed [COORD_W-1:0] vel_a_x;
    logic signed [COORD_W-1:0] vel_a_y;
    logic signed [COORD_W-1:0] vel_b_x;
    logic signed [COORD_W-1:0] vel_b_y;
    logic [MASS_W-1:0]         mass_a;
    logic [MASS_W-1:0]         mass_b;
    logic [REST_W-1:0]         rest_a;
    logic [REST_W-1:0]         rest_b;
  } icr_in_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] new_vel_a_x;
    logic signed [COORD_W-1:0] new_vel_a_y;
    logic signed [COORD_W-1:0] new_vel_b_x;
    logic signed [COORD_W-1:0] new_vel_b_y;
    logic [1:0]                outcome;
  } icr_out_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] vel_a_x;
    logic signed [COORD_W-1:0] vel_a_y;
    logic signed [COORD_W-1:0] vel_b_x;
    logic signed [COORD_W-1:0] vel_b_y;
    logic                      sgn_x;
    logic                      sgn_y;
    logic [1:0]                outcome;
  } icr_side_t;

  typedef struct packed {
    logic [NUM_W-1:0] num_x;
    logic [NUM_W-1:0] num_y;
    logic [DEN_W-1:0] den_q;
    logic [NUM_W-1:0] num_ga;
    logic [NUM_W-1:0] num_gb;
    logic [DEN_W-1:0] den_m;
    icr_side_t        side;
  } icr_geo_t;

endpackage

### design/icr_dly.sv
// Fixed-depth delay line for sideband data with a resettable valid bit.
// Standalone; used alongside the divider pipelines.
module icr_dly #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_vld,
  input  logic [WIDTH-1:0] in_data,
  output logic             out_vld,
  output logic [WIDTH-1:0] out_data
);
  logic [DEPTH-1:0] vld_r;
  logic [WIDTH-1:0] data_r [DEPTH];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[DEPTH-2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    data_r[0] <= in_data;
    for (int i = 1; i < DEPTH; i++) begin
      data_r[i] <= data_r[i-1];
    end
  end

  assign out_vld  = vld_r[DEPTH-1];
  assign out_data = data_r[DEPTH-1];
endmodule

### design/icr_div.sv
// Pipelined restoring divider, one quotient bit per register stage.
// Uses icr_pkg widths; high dividend part must be below the divisor.
module icr_div (
  input  logic                     clk,
  input  logic [icr_pkg::HI_W-1:0]  num_hi,
  input  logic [icr_pkg::QUO_W-1:0] num_lo,
  input  logic [icr_pkg::DEN_W-1:0] den,
  output logic [icr_pkg::QUO_W-1:0] quo
);
  import icr_pkg::*;

  logic [DEN_W-1:0] rem_r  [QUO_W];
  logic [QUO_W-1:0] work_r [QUO_W];
  logic [DEN_W-1:0] den_r  [QUO_W];

  for (genvar g = 0; g < QUO_W; g++) begin : g_step
    logic [DEN_W-1:0] rem_in;
    logic [QUO_W-1:0] work_in;
    logic [DEN_W-1:0] den_in;
    logic [DEN_W:0]   trial;
    logic             ge;
    logic [DEN_W:0]   diff;

    if (g == 0) begin : g_first
      assign rem_in  = DEN_W'(num_hi);
      assign work_in = num_lo;
      assign den_in  = den;
    end else begin : g_next
      assign rem_in  = rem_r[g-1];
      assign work_in = work_r[g-1];
      assign den_in  = den_r[g-1];
    end

    always_comb begin
      trial = {rem_in, work_in[QUO_W-1]};
      ge    = trial >= {1'b0, den_in};
      diff  = trial - {1'b0, den_in};
    end

    always_ff @(posedge clk) begin
      rem_r[g]  <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      work_r[g] <= {work_in[QUO_W-2:0], ge};
      den_r[g]  <= den_in;
    end
  end

  assign quo = work_r[QUO_W-1];
endmodule

### design/icr_geom.sv
// Front pipeline: offsets, normal reduction, dot products and divider operands.
// Uses icr_pkg types; feeds the icr_div instances in the top level.
module icr_geom (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_vld,
  input  icr_pkg::icr_in_t  in_item,
  output logic              out_vld,
  output icr_pkg::icr_geo_t out_geo
);
  import icr_pkg::*;

  function automatic logic [K_W-1:0] msb_idx(input logic [MAG_W-1:0] v);
    logic [K_W-1:0] idx;
    idx = '0;
    for (int i = 0; i < MAG_W; i++) begin
      if (v[i]) idx = K_W'(i);
    end
    return idx;
  endfunction

  logic [GEOM_STAGES-1:0] vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[GEOM_STAGES-2:0], in_vld};
    end
  end

  // stage 1: offsets, restitution and masses
  logic signed [DIFF_W-1:0] s1_dx_r, s1_dy_r, s1_rx_r, s1_ry_r;
  logic [REST_W-1:0]        s1_e_r;
  logic [MASS_W-1:0]        s1_ma_r, s1_mb_r;
  icr_side_t                s1_side_r;
  logic [REST_W-1:0]        e_min;

  always_comb begin
    e_min = (in_item.rest_a < in_item.rest_b) ? in_item.rest_a : in_item.rest_b;
    if (e_min > REST_ONE) e_min = REST_ONE;
  end

  always_ff @(posedge clk) begin
    s1_dx_r <= DIFF_W'(in_item.pos_b_x) - DIFF_W'(in_item.pos_a_x);
    s1_dy_r <= DIFF_W'(in_item.pos_b_y) - DIFF_W'(in_item.pos_a_y);
    s1_rx_r <= DIFF_W'(in_item.vel_b_x) - DIFF_W'(in_item.vel_a_x);
    s1_ry_r <= DIFF_W'(in_item.vel_b_y) - DIFF_W'(in_item.vel_a_y);
    s1_e_r  <= e_min;
    s1_ma_r <= (in_item.mass_a == '0) ? MASS_W'(1) : in_item.mass_a;
    s1_mb_r <= (in_item.mass_b == '0) ? MASS_W'(1) : in_item.mass_b;
    s1_side_r.vel_a_x <= in_item.vel_a_x;
    s1_side_r.vel_a_y <= in_item.vel_a_y;
    s1_side_r.vel_b_x <= in_item.vel_b_x;
    s1_side_r.vel_b_y <= in_item.vel_b_y;
    s1_side_r.sgn_x   <= 1'b0;
    s1_side_r.sgn_y   <= 1'b0;
    s1_side_r.outcome <= OUT_IMPULSE;
  end

  // stage 2: magnitudes
  logic [MAG_W-1:0]         s2_mx_r, s2_my_r;
  logic                     s2_nx_r, s2_ny_r, s2_coin_r;
  logic signed [DIFF_W-1:0] s2_rx_r, s2_ry_r;
  logic [REST_W-1:0]        s2_e_r;
  logic [MASS_W-1:0]        s2_ma_r, s2_mb_r;
  icr_side_t                s2_side_r;

  always_ff @(posedge clk) begin
    s2_mx_r   <= s1_dx_r[DIFF_W-1] ? MAG_W'(-s1_dx_r) : MAG_W'(s1_dx_r);
    s2_my_r   <= s1_dy_r[DIFF_W-1] ? MAG_W'(-s1_dy_r) : MAG_W'(s1_dy_r);
    s2_nx_r   <= s1_dx_r[DIFF_W-1];
    s2_ny_r   <= s1_dy_r[DIFF_W-1];
    s2_coin_r <= (s1_dx_r == '0) && (s1_dy_r == '0);
    s2_rx_r   <= s1_rx_r;
    s2_ry_r   <= s1_ry_r;
    s2_e_r    <= s1_e_r;
    s2_ma_r   <= s1_ma_r;
    s2_mb_r   <= s1_mb_r;
    s2_side_r <= s1_side_r;
  end

  // stage 3: reduced normal
  logic [K_W-1:0]           hi_idx, shamt;
  logic [MAG_W-1:0]         red_x, red_y;
  logic [RM_W-1:0]          s3_ux_r, s3_uy_r;
  logic signed [RED_W-1:0]  s3_drx_r, s3_dry_r;
  logic                     s3_nx_r, s3_ny_r, s3_coin_r;
  logic signed [DIFF_W-1:0] s3_rx_r, s3_ry_r;
  logic [REST_W-1:0]        s3_e_r;
  logic [MASS_W-1:0]        s3_ma_r, s3_mb_r;
  icr_side_t                s3_side_r;

  always_comb begin
    hi_idx = msb_idx(s2_mx_r | s2_my_r);
    shamt  = (hi_idx >= K_W'(RM_W)) ? hi_idx - K_W'(RM_W - 1) : '0;
    red_x  = s2_mx_r >> shamt;
    red_y  = s2_my_r >> shamt;
  end

  always_ff @(posedge clk) begin
    s3_ux_r   <= red_x[RM_W-1:0];
    s3_uy_r   <= red_y[RM_W-1:0];
    s3_drx_r  <= s2_nx_r ? -RED_W'(red_x[RM_W-1:0]) : RED_W'(red_x[RM_W-1:0]);
    s3_dry_r  <= s2_ny_r ? -RED_W'(red_y[RM_W-1:0]) : RED_W'(red_y[RM_W-1:0]);
    s3_nx_r   <= s2_nx_r;
    s3_ny_r   <= s2_ny_r;
    s3_coin_r <= s2_coin_r;
    s3_rx_r   <= s2_rx_r;
    s3_ry_r   <= s2_ry_r;
    s3_e_r    <= s2_e_r;
    s3_ma_r   <= s2_ma_r;
    s3_mb_r   <= s2_mb_r;
    s3_side_r <= s2_side_r;
  end

  // stage 4: products
  logic [SQ_W-1:0]      s4_sqx_r, s4_sqy_r;
  logic signed [S_W-1:0] s4_sx_r, s4_sy_r;
  logic [GNUM_W-1:0]    s4_gna_r, s4_gnb_r;
  logic [MSUM_W-1:0]    s4_msum_r;
  logic [RM_W-1:0]      s4_ux_r, s4_uy_r;
  logic                 s4_nx_r, s4_ny_r, s4_coin_r;
  icr_side_t            s4_side_r;

  always_ff @(posedge clk) begin
    s4_sqx_r  <= SQ_W'(s3_ux_r) * SQ_W'(s3_ux_r);
    s4_sqy_r  <= SQ_W'(s3_uy_r) * SQ_W'(s3_uy_r);
    s4_sx_r   <= S_W'(s3_drx_r) * S_W'(s3_rx_r);
    s4_sy_r   <= S_W'(s3_dry_r) * S_W'(s3_ry_r);
    s4_gna_r  <= (GNUM_W'(s3_e_r) + GNUM_W'(256)) * GNUM_W'(s3_mb_r);
    s4_gnb_r  <= (GNUM_W'(s3_e_r) + GNUM_W'(256)) * GNUM_W'(s3_ma_r);
    s4_msum_r <= MSUM_W'(s3_ma_r) + MSUM_W'(s3_mb_r);
    s4_ux_r   <= s3_ux_r;
    s4_uy_r   <= s3_uy_r;
    s4_nx_r   <= s3_nx_r;
    s4_ny_r   <= s3_ny_r;
    s4_coin_r <= s3_coin_r;
    s4_side_r <= s3_side_r;
  end

  // stage 5: q, s and outcome
  logic signed [S_W-1:0] s_sum;
  logic [DEN_W-1:0]      s5_q_r;
  logic [SMAG_W-1:0]     s5_smag_r;
  logic                  s5_sneg_r;
  logic [GNUM_W-1:0]     s5_gna_r, s5_gnb_r;
  logic [MSUM_W-1:0]     s5_msum_r;
  logic [RM_W-1:0]       s5_ux_r, s5_uy_r;
  logic                  s5_nx_r, s5_ny_r;
  icr_side_t             s5_side_r;

  assign s_sum = s4_sx_r + s4_sy_r;

  always_ff @(posedge clk) begin
    s5_q_r    <= DEN_W'(s4_sqx_r) + DEN_W'(s4_sqy_r);
    s5_smag_r <= s_sum[S_W-1] ? SMAG_W'(-s_sum) : SMAG_W'(s_sum);
    s5_sneg_r <= s_sum[S_W-1];
    s5_gna_r  <= s4_gna_r;
    s5_gnb_r  <= s4_gnb_r;
    s5_msum_r <= s4_msum_r;
    s5_ux_r   <= s4_ux_r;
    s5_uy_r   <= s4_uy_r;
    s5_nx_r   <= s4_nx_r;
    s5_ny_r   <= s4_ny_r;
    s5_side_r.vel_a_x <= s4_side_r.vel_a_x;
    s5_side_r.vel_a_y <= s4_side_r.vel_a_y;
    s5_side_r.vel_b_x <= s4_side_r.vel_b_x;
    s5_side_r.vel_b_y <= s4_side_r.vel_b_y;
    s5_side_r.sgn_x   <= s4_side_r.sgn_x;
    s5_side_r.sgn_y   <= s4_side_r.sgn_y;
    if (s4_coin_r) begin
      s5_side_r.outcome <= OUT_COINCIDE;
    end else if (!s_sum[S_W-1] && s_sum != '0) begin
      s5_side_r.outcome <= OUT_SEPARATE;
    end else begin
      s5_side_r.outcome <= OUT_IMPULSE;
    end
  end

  // stage 6: projection numerators and gain operands
  always_ff @(posedge clk) begin
    out_geo.num_x  <= NUM_W'(s5_smag_r) * NUM_W'(s5_ux_r);
    out_geo.num_y  <= NUM_W'(s5_smag_r) * NUM_W'(s5_uy_r);
    out_geo.den_q  <= s5_q_r;
    out_geo.num_ga <= NUM_W'({s5_gna_r, 8'b0});
    out_geo.num_gb <= NUM_W'({s5_gnb_r, 8'b0});
    out_geo.den_m  <= DEN_W'(s5_msum_r);
    out_geo.side.vel_a_x <= s5_side_r.vel_a_x;
    out_geo.side.vel_a_y <= s5_side_r.vel_a_y;
    out_geo.side.vel_b_x <= s5_side_r.vel_b_x;
    out_geo.side.vel_b_y <= s5_side_r.vel_b_y;
    out_geo.side.outcome <= s5_side_r.outcome;
    out_geo.side.sgn_x   <= s5_sneg_r ^ s5_nx_r;
    out_geo.side.sgn_y   <= s5_sneg_r ^ s5_ny_r;
  end

  assign out_vld = vld_r[GEOM_STAGES-1];
endmodule

### design/icr_apply.sv
// Back pipeline: scale projections by gains, update velocities, saturate.
// Uses icr_pkg types; takes quotients from the icr_div instances.
module icr_apply (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_vld,
  input  icr_pkg::icr_side_t        in_side,
  input  logic [icr_pkg::QUO_W-1:0] quo_x,
  input  logic [icr_pkg::QUO_W-1:0] quo_y,
  input  logic [icr_pkg::QUO_W-1:0] gain_a,
  input  logic [icr_pkg::QUO_W-1:0] gain_b,
  output logic                      out_valid,
  output icr_pkg::icr_out_t         out_item
);
  import icr_pkg::*;

  function automatic logic signed [COORD_W-1:0] upd(
    input logic signed [COORD_W-1:0] v,
    input logic [PROD_W-1:0]         prod,
    input logic                      sub
  );
    logic signed [SUM_W-1:0] term;
    logic signed [SUM_W-1:0] sum;
    term = SUM_W'(prod[PROD_W-1:16]);
    sum  = sub ? SUM_W'(v) - term : SUM_W'(v) + term;
    if (sum > SAT_HI) sum = SAT_HI;
    if (sum < SAT_LO) sum = SAT_LO;
    return sum[COORD_W-1:0];
  endfunction

  logic [APPLY_STAGES-1:0] vld_r;
  logic [PROD_W-1:0]       b1_ax_r, b1_ay_r, b1_bx_r, b1_by_r;
  icr_side_t               b1_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[APPLY_STAGES-2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    b1_ax_r   <= PROD_W'(quo_x) * PROD_W'(gain_a[GAIN_W-1:0]);
    b1_ay_r   <= PROD_W'(quo_y) * PROD_W'(gain_a[GAIN_W-1:0]);
    b1_bx_r   <= PROD_W'(quo_x) * PROD_W'(gain_b[GAIN_W-1:0]);
    b1_by_r   <= PROD_W'(quo_y) * PROD_W'(gain_b[GAIN_W-1:0]);
    b1_side_r <= in_side;
  end

  always_ff @(posedge clk) begin
    out_item.outcome <= b1_side_r.outcome;
    if (b1_side_r.outcome == OUT_IMPULSE) begin
      out_item.new_vel_a_x <= upd(b1_side_r.vel_a_x, b1_ax_r, b1_side_r.sgn_x);
      out_item.new_vel_a_y <= upd(b1_side_r.vel_a_y, b1_ay_r, b1_side_r.sgn_y);
      out_item.new_vel_b_x <= upd(b1_side_r.vel_b_x, b1_bx_r, !b1_side_r.sgn_x);
      out_item.new_vel_b_y <= upd(b1_side_r.vel_b_y, b1_by_r, !b1_side_r.sgn_y);
    end else begin
      out_item.new_vel_a_x <= b1_side_r.vel_a_x;
      out_item.new_vel_a_y <= b1_side_r.vel_a_y;
      out_item.new_vel_b_x <= b1_side_r.vel_b_x;
      out_item.new_vel_b_y <= b1_side_r.vel_b_y;
    end
  end

  assign out_valid = vld_r[APPLY_STAGES-1];
endmodule

### design/impulse_collision_response.sv
// Top level of the 2D impulse collision response pipeline.
// Depends on icr_pkg, icr_geom, icr_div, icr_dly and icr_apply.
//
//   channel  ports                   handshake
//   input    start, busy, in_item    beat taken when start && !busy
//   result   out_valid, out_item     one-cycle strobe, no backpressure
//
// One beat per cycle; busy is always low. A beat passes through
// 6 front stages, one stage per quotient bit in the dividers, and 2 back stages.
// Synchronous reset clears the valid bits only; beats in flight are dropped.
// The receiver cannot stall, so the pipeline never holds.
module impulse_collision_response (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  icr_pkg::icr_in_t  in_item,
  output logic              out_valid,
  output icr_pkg::icr_out_t out_item
);
  import icr_pkg::*;

  logic             geo_vld;
  icr_geo_t         geo;
  logic [QUO_W-1:0] quo_x, quo_y, gain_a, gain_b;
  logic             side_vld;
  icr_side_t        side;

  assign busy = 1'b0;

  icr_geom u_geom (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (start && !busy),
    .in_item (in_item),
    .out_vld (geo_vld),
    .out_geo (geo)
  );

  icr_div u_div_x (
    .clk    (clk),
    .num_hi (geo.num_x[NUM_W-1:QUO_W]),
    .num_lo (geo.num_x[QUO_W-1:0]),
    .den    (geo.den_q),
    .quo    (quo_x)
  );

  icr_div u_div_y (
    .clk    (clk),
    .num_hi (geo.num_y[NUM_W-1:QUO_W]),
    .num_lo (geo.num_y[QUO_W-1:0]),
    .den    (geo.den_q),
    .quo    (quo_y)
  );

  icr_div u_div_ga (
    .clk    (clk),
    .num_hi (geo.num_ga[NUM_W-1:QUO_W]),
    .num_lo (geo.num_ga[QUO_W-1:0]),
    .den    (geo.den_m),
    .quo    (gain_a)
  );

  icr_div u_div_gb (
    .clk    (clk),
    .num_hi (geo.num_gb[NUM_W-1:QUO_W]),
    .num_lo (geo.num_gb[QUO_W-1:0]),
    .den    (geo.den_m),
    .quo    (gain_b)
  );

  icr_dly #(
    .WIDTH ($bits(icr_side_t)),
    .DEPTH (QUO_W)
  ) u_side_dly (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (geo_vld),
    .in_data  (geo.side),
    .out_vld  (side_vld),
    .out_data (side)
  );

  icr_apply u_apply (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_vld    (side_vld),
    .in_side   (side),
    .quo_x     (quo_x),
    .quo_y     (quo_y),
    .gain_a    (gain_a),
    .gain_b    (gain_b),
    .out_valid (out_valid),
    .out_item  (out_item)
  );
endmodule

### design/icr_chk.sv
// Port-level checker for impulse_collision_response, bound to the top level.
// Depends on icr_pkg for latency and outcome codes.
module icr_chk (
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input icr_pkg::icr_in_t  in_item,
  input logic              out_valid,
  input icr_pkg::icr_out_t out_item
);
  import icr_pkg::*;

  a_beat_out: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |-> ##LATENCY out_valid)
    else $error("accepted beat produced no result");

  a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LATENCY))
    else $error("result without an accepted beat");

  a_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.outcome == OUT_IMPULSE ||
                   out_item.outcome == OUT_SEPARATE ||
                   out_item.outcome == OUT_COINCIDE))
    else $error("bad outcome code");

  a_pass: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.outcome != OUT_IMPULSE |->
      out_item.new_vel_a_x == $past(in_item.vel_a_x, LATENCY) &&
      out_item.new_vel_b_y == $past(in_item.vel_b_y, LATENCY))
    else $error("unchanged outcome altered velocities");
endmodule

bind impulse_collision_response icr_chk u_chk (.*);
